// ===== rtl/mfau_pkg.sv =====
// Package for the motor feedback angle unwrap block.
// Holds the frame and result word types, fixed-point constants and codes.
// No dependencies.
package mfau_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int TURN_WIDTH = 24;

	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam int COUNTS_PER_TURN = 8191;

	// angle and speed scale by 2^(FRAC_BITS+8) / 2^29; the common power of two cancels
	localparam int DEN_SH = 29 - (FRAC_BITS + 8);

	// 2*pi rounded half up to FRAC_BITS fraction bits
	localparam longint WRAP_MOD_L =
		(longint'(TWO_PI_Q29) + (longint'(1) << (28 - FRAC_BITS))) >> (29 - FRAC_BITS);

	localparam int MAG_W = 43;            // magnitude of any operand fed to the divider
	localparam int NUM_W = MAG_W + 32;    // dividend after the multiply
	localparam int DEN_W = 35;            // divisor / remainder
	localparam int QUO_W = 42;            // quotient kept before the cap
	localparam int CNT_W = $clog2(NUM_W);
	localparam int CAP_SH = 40;           // magnitude quotient is held at 2^40

	localparam logic [DEN_W-1:0] WRAP_MOD = DEN_W'(WRAP_MOD_L);

	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GEAR_REDUCTION  = 4'd0,
		REG_ANGLE_OFFSET    = 4'd1,
		REG_CONTINUOUS_MODE = 4'd2,
		REG_CURRENT_DIVISOR = 4'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		JOB_ANGLE = 2'd0,
		JOB_SPEED = 2'd1,
		JOB_CUR   = 2'd2,
		JOB_WRAP  = 2'd3
	} job_t;

	typedef struct packed {
		logic [12:0]        angle_raw;
		logic signed [15:0] speed_raw;
		logic signed [15:0] current_raw;
		logic [7:0]         temperature_raw;
	} frame_t;

	typedef struct packed {
		logic signed [31:0]           output_angle;
		logic signed [31:0]           output_speed;
		logic signed [31:0]           output_current;
		logic [7:0]                   output_temperature;
		logic signed [TURN_WIDTH-1:0] turns;
	} result_t;

endpackage

// ===== rtl/motor_feedback_angle_unwrap.sv =====
// From frame acceptance to result valid: turn update, then 3 divider passes in continuous
// mode or 4 in wrapped mode (each through load, multiply, divide and finish states), then
// the done state. Frames are taken one at a time: frame_stall is high outside idle, and a
// stalled result holds the done state. One shared restoring divider, one quotient bit per
// cycle, is reused for the angle, speed, current and wrap reduction.
// Reset clears turn count, previous angle and registers to their defaults. Uses mfau_pkg.
module motor_feedback_angle_unwrap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                frame_valid,
	output logic                                frame_stall,
	input  mfau_pkg::frame_t                    frame,
	output logic                                result_valid,
	input  logic                                result_stall,
	output mfau_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mfau_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data
);
	import mfau_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_TURN = 8'b0000_0010,
		ST_LOAD = 8'b0000_0100,
		ST_MUL0 = 8'b0000_1000,
		ST_MUL1 = 8'b0001_0000,
		ST_DIV  = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;
	job_t   job_q;

	logic [15:0]        gear_q;
	logic signed [31:0] offset_q;
	logic               cont_q;
	logic [15:0]        cdiv_q;

	logic [12:0]                  prev_q;
	logic signed [TURN_WIDTH-1:0] turn_q;
	frame_t                       frame_q;

	logic                 sign_q;
	logic [MAG_W-1:0]     mag_q;
	logic [31:0]          mulb_q;
	logic [63:0]          prod_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     div_d_q;
	logic [DEN_W-1:0]     rem_q;
	logic [QUO_W-1:0]     quo_q;
	logic                 big_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [MAG_W-1:0] ang_v_q;

	logic signed [31:0] ang_out_q, spd_out_q, cur_out_q;
	result_t            res_q;
	logic               res_valid_q;

	function automatic logic signed [31:0] sat32(input logic signed [MAG_W-1:0] v);
		if (v > MAG_W'(signed'(32'sh7FFFFFFF)))
			return 32'sh7FFFFFFF;
		else if (v < MAG_W'(signed'(32'sh80000000)))
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// operand selection for the shared divider
	logic [15:0]             gr_eff, cd_eff;
	logic signed [MAG_W-1:0] load_v;
	logic [31:0]             load_b;
	logic [DEN_W-1:0]        load_d;

	always_comb begin
		gr_eff = (gear_q == '0) ? 16'd1 : gear_q;
		cd_eff = (cdiv_q == '0) ? 16'd1 : cdiv_q;
		case (job_q)
			JOB_ANGLE: begin
				load_v = (MAG_W'(turn_q) <<< 13) - MAG_W'(turn_q)
					+ MAG_W'(signed'({1'b0, frame_q.angle_raw}));
				load_b = TWO_PI_Q29;
				load_d = (DEN_W'(COUNTS_PER_TURN) * DEN_W'(gr_eff)) << DEN_SH;
			end
			JOB_SPEED: begin
				load_v = MAG_W'(frame_q.speed_raw);
				load_b = TWO_PI_Q29;
				load_d = (DEN_W'(60) * DEN_W'(gr_eff)) << DEN_SH;
			end
			JOB_CUR: begin
				load_v = MAG_W'(frame_q.current_raw);
				load_b = 32'd1 << FRAC_BITS;
				load_d = DEN_W'(cd_eff);
			end
			default: begin
				load_v = ang_v_q;
				load_b = 32'd1;
				load_d = WRAP_MOD;
			end
		endcase
	end

	// one divider step
	logic [DEN_W:0]   div_shift;
	logic             div_ge;
	logic [DEN_W:0]   div_sub;

	assign div_shift = {rem_q, num_q[NUM_W-1]};
	assign div_ge    = div_shift >= {1'b0, div_d_q};
	assign div_sub   = div_shift - {1'b0, div_d_q};

	// finish: round half away from zero, cap, sign, subtract offset, wrap output
	logic                    rnd;
	logic [QUO_W:0]          qsum;
	logic [CAP_SH:0]         qf;
	logic signed [MAG_W-1:0] sq;
	logic signed [MAG_W-1:0] ang_v;
	logic [31:0]             wrap_out;

	always_comb begin
		rnd  = {rem_q, 1'b0} >= {1'b0, div_d_q};
		qsum = {1'b0, quo_q} + (QUO_W+1)'(rnd);
		if (big_q || quo_q[QUO_W-1] || qsum > ((QUO_W+1)'(1) << CAP_SH))
			qf = (CAP_SH+1)'(1) << CAP_SH;
		else
			qf = qsum[CAP_SH:0];
		sq    = sign_q ? -signed'(MAG_W'(qf)) : signed'(MAG_W'(qf));
		ang_v = sq - MAG_W'(offset_q);
		if (ang_v_q == '0)
			wrap_out = '0;
		else if (ang_v_q[MAG_W-1])
			wrap_out = (rem_q == '0) ? 32'd0 : 32'(WRAP_MOD - rem_q);
		else
			wrap_out = (rem_q == '0) ? 32'(WRAP_MOD) : 32'(rem_q);
	end

	logic signed [15:0] diff4;
	assign diff4 = 16'(signed'({3'b000, frame_q.angle_raw}) - signed'({3'b000, prev_q})) <<< 2;

	logic out_free;
	assign out_free    = !res_valid_q || !result_stall;
	assign frame_stall = (state_q != ST_IDLE);
	assign cfg_ready   = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_q   <= 16'd256;
			offset_q <= '0;
			cont_q   <= 1'b0;
			cdiv_q   <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GEAR_REDUCTION:  gear_q   <= cfg_data[15:0];
				REG_ANGLE_OFFSET:    offset_q <= cfg_data;
				REG_CONTINUOUS_MODE: cont_q   <= cfg_data[0];
				REG_CURRENT_DIVISOR: cdiv_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_ANGLE;
			prev_q      <= '0;
			turn_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (frame_valid)
						state_q <= ST_TURN;
				end
				ST_TURN: begin
					if (diff4 < -16'sd8191) begin
						if (turn_q != {1'b0, {(TURN_WIDTH-1){1'b1}}})
							turn_q <= turn_q + TURN_WIDTH'(1);
					end else if (diff4 > 16'sd8191) begin
						if (turn_q != {1'b1, {(TURN_WIDTH-1){1'b0}}})
							turn_q <= turn_q - TURN_WIDTH'(1);
					end
					prev_q  <= frame_q.angle_raw;
					job_q   <= JOB_ANGLE;
					state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					case (job_q)
						JOB_ANGLE: begin
							job_q <= JOB_SPEED;
							state_q <= ST_LOAD;
						end
						JOB_SPEED: begin
							job_q <= JOB_CUR;
							state_q <= ST_LOAD;
						end
						JOB_CUR: begin
							if (cont_q) begin
								state_q <= ST_DONE;
							end else begin
								job_q <= JOB_WRAP;
								state_q <= ST_LOAD;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (frame_valid)
					frame_q <= frame;
			end
			ST_LOAD: begin
				sign_q  <= load_v[MAG_W-1];
				mag_q   <= load_v[MAG_W-1] ? MAG_W'(-load_v) : MAG_W'(load_v);
				mulb_q  <= load_b;
				div_d_q <= load_d;
			end
			ST_MUL0: prod_q <= 64'(mag_q[31:0]) * 64'(mulb_q);
			ST_MUL1: begin
				num_q <= NUM_W'(prod_q)
					+ (NUM_W'(mag_q[MAG_W-1:32] * mulb_q) << 32);
				rem_q <= '0;
				quo_q <= '0;
				big_q <= 1'b0;
				cnt_q <= CNT_W'(NUM_W - 1);
			end
			ST_DIV: begin
				// shift in one dividend bit, subtract when it fits
				rem_q <= div_ge ? div_sub[DEN_W-1:0] : div_shift[DEN_W-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[QUO_W-2:0], div_ge};
				if (quo_q[QUO_W-1])
					big_q <= 1'b1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_FIN: begin
				case (job_q)
					JOB_ANGLE: begin
						ang_v_q   <= ang_v;
						ang_out_q <= sat32(ang_v);
					end
					JOB_SPEED: spd_out_q <= sat32(sq);
					JOB_CUR:   cur_out_q <= sat32(sq);
					default:   ang_out_q <= wrap_out;
				endcase
			end
			ST_DONE: begin
				if (out_free) begin
					res_q.output_angle       <= ang_out_q;
					res_q.output_speed       <= spd_out_q;
					res_q.output_current     <= cur_out_q;
					res_q.output_temperature <= frame_q.temperature_raw;
					res_q.turns              <= turn_q;
				end
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_d_q != '0)
		else $error("divider runs with zero divisor");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_d_q)
		else $error("remainder not below divisor");

	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_TURN |=> turn_q == $past(turn_q))
		else $error("turn count changed outside turn update");

	a_accept_turn: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && !frame_stall |=> state_q == ST_TURN)
		else $error("accepted word did not start turn update");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside done state");
`endif

endmodule
